FILE: hw/rtl/virtqueue_ring_controller_top_macros.svh
// assertion helpers used by the top module
`ifndef VIRTQUEUE_RING_CONTROLLER_TOP_MACROS_SVH
`define VIRTQUEUE_RING_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define VQRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VQRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/vqrc_pkg.sv
`timescale 1ns / 1ps
package vqrc_pkg;

    localparam int unsigned MAX_DESCRIPTORS = 256;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned IN_USER_W  = 6;
    localparam int unsigned OUT_DATA_W = 160;
    localparam int unsigned OUT_USER_W = 4;

    // actions
    localparam logic [2:0] ACT_REG_READ    = 3'd0;
    localparam logic [2:0] ACT_REG_WRITE   = 3'd1;
    localparam logic [2:0] ACT_FETCH_AVAIL = 3'd2;
    localparam logic [2:0] ACT_PUSH_USED   = 3'd3;
    localparam logic [2:0] ACT_DECODE_DESC = 3'd4;
    localparam logic [2:0] ACT_LOCATE_DESC = 3'd5;
    localparam logic [2:0] ACT_RESET       = 3'd6;

    // register selectors
    localparam logic [2:0] REG_MAX       = 3'd0;
    localparam logic [2:0] REG_SIZE      = 3'd1;
    localparam logic [2:0] REG_READY     = 3'd2;
    localparam logic [2:0] REG_NOTIFY    = 3'd3;
    localparam logic [2:0] REG_DESC_BASE = 3'd4;
    localparam logic [2:0] REG_AVAIL_BASE = 3'd5;
    localparam logic [2:0] REG_USED_BASE = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NO_NEXT   = 2'd3;

    // classified transaction as it sits in the queue
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  reg_sel;
        logic [31:0] write_value;
        logic [15:0] driver_avail_index;
        logic [15:0] desc_index;
        logic [15:0] desc_flags;
        logic [15:0] desc_next;
        logic [31:0] used_length;
        logic        size_ok;
    } op_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic [31:0] mem_address;
        logic [31:0] used_counter_address;
        logic [15:0] entry_id;
        logic [31:0] entry_length;
        logic        notify_pulse;
        logic [15:0] next_index;
        logic        to_host;
    } res_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } q_status_t;

endpackage

FILE: hw/rtl/virtqueue_ring_controller_top.sv
`timescale 1ns / 1ps
// device side of one split virtqueue: queue registers, avail and used cursors
// s_axis carries one action per transaction; tuser holds action and register
// selector, tdata the write value, driver avail index and descriptor words
// m_axis returns exactly one result transaction per action, in order
// a result is registered in the queue and then in the output register after its action is accepted
// throughput: one action per cycle while m_axis_tready stays high; the back end
// updates ring state and output register together, so actions stream back to back
// a 2-entry queue sits between the classifier and the executing back end
// when m_axis_tready is low the output register holds its result, the queue
// fills, and s_axis_tready drops once both entries are taken
// no transaction is lost or repeated across a stall
// reset (rst_n low) empties the queue, drops m_axis_tvalid and clears the
// ring mask, ready word, cursors and base addresses; the reset action does
// the same to the ring state in band, behind any actions still queued
module virtqueue_ring_controller_top import vqrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // write_value, driver_avail_index, desc_index, desc_flags, desc_next, used_length
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action, reg_sel
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, mem_address, used_counter_address, entry_id, entry_length, next_index
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status, notify_pulse, to_host
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

`include "virtqueue_ring_controller_top_macros.svh"

    logic      push;
    logic      pop;
    op_t       push_op;
    op_t       head_op;
    q_status_t q_status;
    res_t      res;

    vqrc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .op            (push_op)
    );

    vqrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    vqrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (head_op),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.next_index, res.entry_length, res.entry_id,
                           res.used_counter_address, res.mem_address, res.read_data};
    assign m_axis_tuser = {res.to_host, res.notify_pulse, res.status};

    `VQRC_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= QUEUE_CW'(QUEUE_DEPTH),
        "queue count beyond depth")
    `VQRC_ASSERT_NEXT(a_head_moves, !q_status.empty && (!m_axis_tvalid || m_axis_tready),
        m_axis_tvalid, "queued action not moved to output")
    `VQRC_ASSERT_NOW(a_notify_clean, m_axis_tvalid && res.notify_pulse,
        res.status == ST_OK && res.mem_address == 32'd0, "notify result carries data")
    `VQRC_ASSERT_NOW(a_fail_no_addr,
        m_axis_tvalid && (res.status == ST_NOT_READY || res.status == ST_EMPTY),
        res.mem_address == 32'd0, "failed fetch gives an address")

endmodule

FILE: hw/rtl/vqrc_front.sv
`timescale 1ns / 1ps
module vqrc_front import vqrc_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  q_status_t            q_status,
    output logic                 push,
    output op_t                  op
);

    logic [31:0] wval;

    assign wval = s_axis_tdata[31:0];

    always_comb
    begin
        op.action             = s_axis_tuser[2:0];
        op.reg_sel            = s_axis_tuser[5:3];
        op.write_value        = wval;
        op.driver_avail_index = s_axis_tdata[47:32];
        op.desc_index         = s_axis_tdata[63:48];
        op.desc_flags         = s_axis_tdata[79:64];
        op.desc_next          = s_axis_tdata[95:80];
        op.used_length        = s_axis_tdata[127:96];
        // power of two, nonzero, within the ring limit
        op.size_ok            = (wval != 32'd0) && ((wval & (wval - 32'd1)) == 32'd0) &&
                                (wval <= 32'(MAX_DESCRIPTORS));
    end

    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && !q_status.full;

endmodule

FILE: hw/rtl/vqrc_queue.sv
`timescale 1ns / 1ps
module vqrc_queue import vqrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_t       push_op,
    input  logic      pop,
    output op_t       head_op,
    output q_status_t q_status
);

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

endmodule

FILE: hw/rtl/vqrc_back.sv
`timescale 1ns / 1ps
module vqrc_back import vqrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  op_t       head_op,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    logic [15:0] ring_mask_reg;
    logic [15:0] ring_mask_next;
    logic [31:0] ready_word_reg;
    logic [31:0] ready_word_next;
    logic [15:0] avail_cursor_reg;
    logic [15:0] avail_cursor_next;
    logic [15:0] used_cursor_reg;
    logic [15:0] used_cursor_next;
    logic [31:0] desc_base_reg;
    logic [31:0] desc_base_next;
    logic [31:0] avail_base_reg;
    logic [31:0] avail_base_next;
    logic [31:0] used_base_reg;
    logic [31:0] used_base_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;
    res_t        res_next;

    logic [15:0] avail_slot;
    logic [15:0] used_slot;
    logic [31:0] desc_addr;

    // take the queue head whenever the output register is free or draining
    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    assign avail_slot = avail_cursor_reg & ring_mask_reg;
    assign used_slot  = used_cursor_reg & ring_mask_reg;
    assign desc_addr  = desc_base_reg + {12'd0, head_op.desc_index, 4'd0};

    always_comb
    begin
        ring_mask_next    = ring_mask_reg;
        ready_word_next   = ready_word_reg;
        avail_cursor_next = avail_cursor_reg;
        used_cursor_next  = used_cursor_reg;
        desc_base_next    = desc_base_reg;
        avail_base_next   = avail_base_reg;
        used_base_next    = used_base_reg;
        res_next          = '0;

        case (head_op.action)
            ACT_REG_READ:
            begin
                case (head_op.reg_sel)
                    REG_MAX:        res_next.read_data = 32'(MAX_DESCRIPTORS);
                    REG_SIZE:       res_next.read_data = {16'd0, ring_mask_reg} + 32'd1;
                    REG_READY:      res_next.read_data = ready_word_reg;
                    REG_DESC_BASE:  res_next.read_data = desc_base_reg;
                    REG_AVAIL_BASE: res_next.read_data = avail_base_reg;
                    REG_USED_BASE:  res_next.read_data = used_base_reg;
                    default:        res_next.read_data = 32'd0;
                endcase
            end
            ACT_REG_WRITE:
            begin
                case (head_op.reg_sel)
                    REG_SIZE:
                    begin
                        ring_mask_next = head_op.size_ok ?
                                         head_op.write_value[15:0] - 16'd1 : 16'd0;
                    end
                    REG_READY:
                    begin
                        if (ring_mask_reg != 16'd0)
                        begin
                            ready_word_next = head_op.write_value;
                        end
                    end
                    REG_NOTIFY:     res_next.notify_pulse = 1'b1;
                    REG_DESC_BASE:  desc_base_next  = head_op.write_value;
                    REG_AVAIL_BASE: avail_base_next = head_op.write_value;
                    REG_USED_BASE:  used_base_next  = head_op.write_value;
                    default:        res_next.notify_pulse = 1'b0;
                endcase
            end
            ACT_FETCH_AVAIL:
            begin
                if (ready_word_reg == 32'd0)
                begin
                    res_next.status = ST_NOT_READY;
                end
                else if (avail_slot == (head_op.driver_avail_index & ring_mask_reg))
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.mem_address = avail_base_reg + 32'd4 + {15'd0, avail_slot, 1'b0};
                    avail_cursor_next    = avail_slot + 16'd1;
                end
            end
            ACT_PUSH_USED:
            begin
                res_next.mem_address          = used_base_reg + 32'd4 +
                                                {13'd0, used_slot, 3'd0};
                res_next.used_counter_address = used_base_reg + 32'd2;
                res_next.entry_id             = head_op.desc_index;
                res_next.entry_length         = head_op.used_length;
                used_cursor_next              = used_slot + 16'd1;
            end
            ACT_DECODE_DESC:
            begin
                res_next.mem_address = desc_addr;
                res_next.to_host     = head_op.desc_flags[1];
                if (head_op.desc_flags[0])
                begin
                    res_next.next_index = head_op.desc_next;
                end
                else
                begin
                    res_next.status = ST_NO_NEXT;
                end
            end
            ACT_LOCATE_DESC:
            begin
                if (head_op.desc_index <= ring_mask_reg)
                begin
                    res_next.mem_address = desc_addr;
                    res_next.to_host     = head_op.desc_flags[1];
                end
                else
                begin
                    res_next.status = ST_NO_NEXT;
                end
            end
            ACT_RESET:
            begin
                ring_mask_next    = 16'd0;
                ready_word_next   = 32'd0;
                avail_cursor_next = 16'd0;
                used_cursor_next  = 16'd0;
                desc_base_next    = 32'd0;
                avail_base_next   = 32'd0;
                used_base_next    = 32'd0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_mask_reg    <= '0;
            ready_word_reg   <= '0;
            avail_cursor_reg <= '0;
            used_cursor_reg  <= '0;
            desc_base_reg    <= '0;
            avail_base_reg   <= '0;
            used_base_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                ring_mask_reg    <= ring_mask_next;
                ready_word_reg   <= ready_word_next;
                avail_cursor_reg <= avail_cursor_next;
                used_cursor_reg  <= used_cursor_next;
                desc_base_reg    <= desc_base_next;
                avail_base_reg   <= avail_base_next;
                used_base_reg    <= used_base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: sim/virtqueue_ring_controller_checker.sv
`timescale 1ns / 1ps
module virtqueue_ring_controller_checker import vqrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // write_value, driver_avail_index, desc_index, desc_flags, desc_next, used_length
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action, reg_sel
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, mem_address, used_counter_address, entry_id, entry_length, next_index
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status, notify_pulse, to_host
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    pending,
    output int                    fail_count
);

    logic [15:0] ring_mask;
    logic [31:0] ready_word;
    logic [15:0] avail_cursor;
    logic [15:0] used_cursor;
    logic [31:0] desc_base;
    logic [31:0] avail_base;
    logic [31:0] used_base;

    res_t expected_results[$];

    task automatic clear_ring_state();
        ring_mask    = '0;
        ready_word   = '0;
        avail_cursor = '0;
        used_cursor  = '0;
        desc_base    = '0;
        avail_base   = '0;
        used_base    = '0;
    endtask

    // works out the result of one action and moves the ring state along
    task automatic predict_ring_action(input logic [IN_USER_W-1:0] user,
                                       input logic [IN_DATA_W-1:0] data,
                                       output res_t r);
        logic [2:0]  act;
        logic [2:0]  sel;
        logic [31:0] wval;
        logic [15:0] drv;
        logic [15:0] didx;
        logic [15:0] flags;
        logic [15:0] dnext;
        logic [31:0] ulen;
        logic [15:0] idx;
        act   = user[2:0];
        sel   = user[5:3];
        wval  = data[31:0];
        drv   = data[47:32];
        didx  = data[63:48];
        flags = data[79:64];
        dnext = data[95:80];
        ulen  = data[127:96];
        r     = '0;
        case (act)
            ACT_REG_READ:
            begin
                case (sel)
                    REG_MAX:        r.read_data = MAX_DESCRIPTORS;
                    REG_SIZE:       r.read_data = {16'd0, ring_mask} + 32'd1;
                    REG_READY:      r.read_data = ready_word;
                    REG_DESC_BASE:  r.read_data = desc_base;
                    REG_AVAIL_BASE: r.read_data = avail_base;
                    REG_USED_BASE:  r.read_data = used_base;
                    default:        r.read_data = '0;
                endcase
            end
            ACT_REG_WRITE:
            begin
                case (sel)
                    REG_SIZE:
                    begin
                        // only a power of two up to the maximum makes a mask
                        if (wval != 0 && (wval & (wval - 32'd1)) == 0 &&
                            wval <= MAX_DESCRIPTORS)
                            ring_mask = 16'(wval - 32'd1);
                        else
                            ring_mask = '0;
                    end
                    REG_READY:
                    begin
                        if (ring_mask != 0)
                            ready_word = wval;
                    end
                    REG_NOTIFY:     r.notify_pulse = 1'b1;
                    REG_DESC_BASE:  desc_base = wval;
                    REG_AVAIL_BASE: avail_base = wval;
                    REG_USED_BASE:  used_base = wval;
                    default:        ;
                endcase
            end
            ACT_FETCH_AVAIL:
            begin
                idx = avail_cursor & ring_mask;
                if (ready_word == 0)
                    r.status = ST_NOT_READY;
                else if (idx == (drv & ring_mask))
                    r.status = ST_EMPTY;
                else
                begin
                    r.mem_address = avail_base + 32'd4 + {15'd0, idx, 1'b0};
                    avail_cursor  = idx + 16'd1;
                end
            end
            ACT_PUSH_USED:
            begin
                idx = used_cursor & ring_mask;
                r.mem_address          = used_base + 32'd4 + {13'd0, idx, 3'd0};
                r.used_counter_address = used_base + 32'd2;
                r.entry_id             = didx;
                r.entry_length         = ulen;
                used_cursor            = idx + 16'd1;
            end
            ACT_DECODE_DESC:
            begin
                r.mem_address = desc_base + {12'd0, didx, 4'd0};
                r.to_host     = flags[1];
                if (flags[0])
                    r.next_index = dnext;
                else
                    r.status = ST_NO_NEXT;
            end
            ACT_LOCATE_DESC:
            begin
                if (didx <= ring_mask)
                begin
                    r.mem_address = desc_base + {12'd0, didx, 4'd0};
                    r.to_host     = flags[1];
                end
                else
                    r.status = ST_NO_NEXT;
            end
            ACT_RESET:      clear_ring_state();
            default:        ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t r;
        if (!rst_n)
        begin
            clear_ring_state();
            expected_results.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("read_data", want.read_data, m_axis_tdata[31:0]);
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
                    compare_field("mem_address", want.mem_address, m_axis_tdata[63:32]);
                    compare_field("used_counter_address", want.used_counter_address,
                                  m_axis_tdata[95:64]);
                    compare_field("entry_id", 32'(want.entry_id),
                                  32'(m_axis_tdata[111:96]));
                    compare_field("entry_length", want.entry_length,
                                  m_axis_tdata[143:112]);
                    compare_field("notify_pulse", 32'(want.notify_pulse),
                                  32'(m_axis_tuser[2]));
                    compare_field("next_index", 32'(want.next_index),
                                  32'(m_axis_tdata[159:144]));
                    compare_field("to_host", 32'(want.to_host), 32'(m_axis_tuser[3]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_ring_action(s_axis_tuser, s_axis_tdata, r);
                expected_results.push_back(r);
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: sim/virtqueue_ring_controller_top_tb.sv
`timescale 1ns / 1ps
module virtqueue_ring_controller_top_tb;
    import vqrc_pkg::*;

    localparam int RANDOM_ACTIONS = 1850;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int pending;
    int fail_count;
    int cycle_count;
    bit steady_run;

    virtqueue_ring_controller_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    virtqueue_ring_controller_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one action per call, after a random gap with tvalid low (no gap in a steady run)
    task automatic offer_action(input logic [2:0] act, input logic [2:0] sel,
                                input logic [31:0] wval, input logic [15:0] drv,
                                input logic [15:0] didx, input logic [15:0] flags,
                                input logic [15:0] dnext, input logic [31:0] ulen);
        int gap;
        gap = steady_run ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {sel, act};
        s_axis_tdata  = {ulen, dnext, flags, didx, drv, wval};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [31:0] wval);
        offer_action(ACT_REG_WRITE, sel, wval, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic read_reg(input logic [2:0] sel);
        offer_action(ACT_REG_READ, sel, $urandom, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return 32'd1 << $urandom_range(0, 8);
        else if (pick == 8)
            return 32'd512;
        return $urandom;
    endfunction

    // queue bring-up: size (not always a valid one), ring bases, then ready
    task automatic bring_up_queue(inout int sent);
        write_reg(REG_SIZE, pick_size());
        write_reg(REG_DESC_BASE, $urandom);
        write_reg(REG_AVAIL_BASE, $urandom);
        write_reg(REG_USED_BASE, $urandom);
        write_reg(REG_READY, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
        sent += 5;
    endtask

    // receiver: random stalls, plus long hold-offs that back the block up
    initial
    begin
        int stall;
        int received;
        received      = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (received == 300 || received == 1200)
                stall = LONG_HOLD;
            else if (steady_run)
                stall = 0;
            else
                stall = $urandom_range(0, 12);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            received++;
        end
    end

    initial
    begin
        int sent;
        int pick;
        logic [2:0]  act;
        logic [2:0]  sel;
        logic [31:0] wval;
        logic [15:0] drv;
        logic [15:0] didx;
        logic [15:0] flags;
        logic [15:0] dnext;
        logic [31:0] ulen;
        logic [15:0] driver_word;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        steady_run    = 1'b0;
        cycle_count   = 0;
        sent          = 0;
        driver_word   = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: register rules first, then every action at the extremes
        read_reg(REG_MAX);
        read_reg(REG_SIZE);
        write_reg(REG_READY, 32'hFFFF_FFFF);
        read_reg(REG_READY);
        offer_action(ACT_FETCH_AVAIL, REG_MAX, 0, 16'h0001, 0, 0, 0, 0);
        write_reg(REG_SIZE, 32'd0);
        write_reg(REG_SIZE, 32'd512);
        write_reg(REG_SIZE, 32'd300);
        write_reg(REG_SIZE, MAX_DESCRIPTORS);
        read_reg(REG_SIZE);
        write_reg(REG_DESC_BASE, 32'hFFFF_FFF0);
        write_reg(REG_AVAIL_BASE, 32'hFFFF_FFFE);
        write_reg(REG_USED_BASE, 32'hFFFF_FFFC);
        write_reg(REG_READY, 32'hFFFF_FFFF);
        write_reg(REG_NOTIFY, 32'hFFFF_FFFF);
        write_reg(REG_MAX, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'hFFFF_FFFF);
        read_reg(REG_NOTIFY);
        read_reg(3'd7);
        offer_action(ACT_FETCH_AVAIL, 0, 0, 16'h0000, 0, 0, 0, 0);
        offer_action(ACT_FETCH_AVAIL, 0, 0, 16'hFFFF, 0, 0, 0, 0);
        offer_action(ACT_PUSH_USED, 0, 0, 0, 16'hFFFF, 0, 0, 32'hFFFF_FFFF);
        offer_action(ACT_DECODE_DESC, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        offer_action(ACT_DECODE_DESC, 0, 0, 0, 16'h0000, 16'h0000, 16'h1234, 0);
        offer_action(ACT_LOCATE_DESC, 0, 0, 0, 16'd255, 16'h0002, 0, 0);
        offer_action(ACT_LOCATE_DESC, 0, 0, 0, 16'd256, 16'h0002, 0, 0);
        offer_action(3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 32'hFFFF_FFFF);
        offer_action(ACT_RESET, 0, 0, 0, 0, 0, 0, 0);
        read_reg(REG_DESC_BASE);

        while (sent < RANDOM_ACTIONS)
        begin
            if (sent % 150 == 0)
            begin
                steady_run = ($urandom_range(0, 3) == 0);
                bring_up_queue(sent);
            end
            if (sent >= 900 && sent < 906)
            begin
                // sender pause until the block has drained
                wait_for_results();
                sent = 906;
            end
            pick  = $urandom_range(0, 99);
            sel   = 3'($urandom_range(0, 7));
            wval  = $urandom;
            drv   = 16'($urandom);
            didx  = 16'($urandom);
            flags = 16'($urandom);
            dnext = 16'($urandom);
            ulen  = $urandom;
            if (pick < 8)
                act = ACT_REG_READ;
            else if (pick < 18)
            begin
                act = ACT_REG_WRITE;
                if (sel == REG_SIZE)
                    wval = pick_size();
            end
            else if (pick < 46)
            begin
                act = ACT_FETCH_AVAIL;
                // half the time a driver index running a little ahead of the device
                driver_word += 16'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    drv = driver_word;
            end
            else if (pick < 66)
                act = ACT_PUSH_USED;
            else if (pick < 81)
                act = ACT_DECODE_DESC;
            else if (pick < 96)
            begin
                act = ACT_LOCATE_DESC;
                if ($urandom_range(0, 3) != 0)
                    didx = 16'($urandom_range(0, 300));
            end
            else if (pick < 98)
                act = ACT_RESET;
            else
                act = 3'd7;
            offer_action(act, sel, wval, drv, didx, flags, dnext, ulen);
            sent++;
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
